// ===== design/swrc_pkg.sv =====
package swrc_pkg;

  // Shared multiply/divide unit: one bit of the operand per cycle
  localparam int MDU_STEPS = 32;
  localparam int MDU_CW    = $clog2(MDU_STEPS);
  localparam int MDU_LAST_I = MDU_STEPS - 1;
  localparam logic [MDU_CW-1:0] MDU_LAST = MDU_LAST_I[MDU_CW-1:0];

  // Item kinds
  typedef enum logic [1:0] {
    KIND_UPDATE    = 2'd0,
    KIND_TOTAL     = 2'd1,
    KIND_OVERSHOOT = 2'd2,
    KIND_UNUSED    = 2'd3
  } kind_t;

  // Configuration register indexes
  localparam logic [0:0] REG_PERIOD = 1'b0;
  localparam logic [0:0] REG_TARGET = 1'b1;

  typedef enum logic [1:0] {
    MDU_MUL = 2'd0,  // acc = a * b
    MDU_MAC = 2'd1,  // acc = acc + a * b
    MDU_DIV = 2'd2   // acc[31:0] = acc / b, acc[63:32] < b on entry
  } mdu_op_t;

  typedef struct packed {
    logic        start;
    mdu_op_t     op;
    logic [32:0] a;
    logic [31:0] b;
  } mdu_cmd_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] acc;
  } mdu_rsp_t;

endpackage

// ===== design/swrc_mdu.sv =====
module swrc_mdu (
  input  logic               clk,
  input  logic               rst_n,
  input  swrc_pkg::mdu_cmd_t cmd,
  output swrc_pkg::mdu_rsp_t rsp
);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  swrc_pkg::mdu_op_t          op_r, op_nxt;
  logic [63:0]                acc_r, acc_nxt;
  logic [63:0]                mcand_r, mcand_nxt;
  logic [31:0]                opb_r, opb_nxt;
  logic [swrc_pkg::MDU_CW-1:0] cnt_r, cnt_nxt;
  logic [31:0]                div_trial;
  logic [31:0]                div_rem;
  logic                       div_ge;

  // Restoring divide step: remainder in acc[63:32], quotient shifts into acc[31:0]
  always_comb begin
    div_trial = {acc_r[62:32], acc_r[31]};
    div_ge    = (div_trial >= opb_r);
    div_rem   = div_ge ? (div_trial - opb_r) : div_trial;
  end

  // Step sequencing
  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    op_nxt    = op_r;
    acc_nxt   = acc_r;
    mcand_nxt = mcand_r;
    opb_nxt   = opb_r;
    cnt_nxt   = cnt_r;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      op_nxt   = cmd.op;
      opb_nxt  = cmd.b;
      unique case (cmd.op) inside
        swrc_pkg::MDU_MUL: begin
          acc_nxt   = '0;
          mcand_nxt = {31'b0, cmd.a};
        end
        swrc_pkg::MDU_MAC: begin
          mcand_nxt = {31'b0, cmd.a};
        end
        swrc_pkg::MDU_DIV: begin
        end
        default: begin
        end
      endcase
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == swrc_pkg::MDU_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
      unique case (op_r) inside
        swrc_pkg::MDU_MUL, swrc_pkg::MDU_MAC: begin
          if (opb_r[0]) begin
            acc_nxt = acc_r + mcand_r;
          end
          mcand_nxt = {mcand_r[62:0], 1'b0};
          opb_nxt   = {1'b0, opb_r[31:1]};
        end
        swrc_pkg::MDU_DIV: begin
          acc_nxt = {div_rem, acc_r[30:0], div_ge};
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= swrc_pkg::MDU_MUL;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    opb_r   <= opb_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.acc  = acc_r;

endmodule

// ===== design/sliding_window_rate_counter.sv =====
// Channel  | Direction | Handshake            | Payload
// in       | input     | in_valid / in_stall  | in_kind, in_now_ms, in_increment, in_pending
// out      | output    | out_valid / out_stall| out_update_count, out_total_events, out_overshoot
// cfg      | input     | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// One item at a time: an update runs through ST_UPD (and ST_ROT when the buckets rotate);
// a total and an overshoot each make two 32-step passes through the shared multiply/divide
// unit, unless they finish early.
// Reset (rst_n low, synchronous) clears the counts, the period start and the handshakes
// and loads period_ms = 1000, target_rate = 0.
// The result sits in an output register; a new beat is taken while it waits, and a
// finished result waits for the output register before the block turns idle again.
module sliding_window_rate_counter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic [31:0]        in_now_ms,
  input  logic [31:0]        in_increment,
  input  logic signed [31:0] in_pending,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_update_count,
  output logic [63:0]        out_total_events,
  output logic signed [31:0] out_overshoot,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPD,
    ST_ROT,
    ST_TOT0,
    ST_TOT1,
    ST_TOT_P1,
    ST_TOT_P2,
    ST_OVS0,
    ST_OVS_MUL,
    ST_OVS_DIV,
    ST_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [30:0]        period_r, period_nxt;
  logic [31:0]        target_r, target_nxt;
  logic [31:0]        start_r, start_nxt;
  logic [31:0]        cur_r, cur_nxt;
  logic [31:0]        prev_r, prev_nxt;
  logic [31:0]        now_r, now_nxt;
  logic [31:0]        inc_r, inc_nxt;
  logic [31:0]        pend_r, pend_nxt;
  logic [31:0]        tmp_r, tmp_nxt;
  logic [32:0]        tot_a_r, tot_a_nxt;
  logic [31:0]        res_upd_r, res_upd_nxt;
  logic [63:0]        res_tot_r, res_tot_nxt;
  logic [31:0]        res_ovs_r, res_ovs_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_upd_r, out_upd_nxt;
  logic [63:0]        out_tot_r, out_tot_nxt;
  logic [31:0]        out_ovs_r, out_ovs_nxt;

  swrc_pkg::mdu_cmd_t mdu_cmd;
  swrc_pkg::mdu_rsp_t mdu_rsp;

  logic [31:0]        p_ext;
  logic [31:0]        upd_dist;
  logic [31:0]        rot_dist;
  logic [31:0]        remain;
  logic               stale;
  logic [31:0]        past;
  logic [31:0]        cur_eff;
  logic [31:0]        pend_eff;
  logic               flap;
  logic [31:0]        elapsed;

  swrc_mdu u_mdu (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (mdu_cmd),
    .rsp   (mdu_rsp)
  );

  // Datapath terms used by the sequencer
  always_comb begin
    p_ext    = {1'b0, period_r};
    upd_dist = now_r - start_r;
    rot_dist = now_r - tmp_r;
    stale    = tmp_r[31];
    remain   = stale ? (tmp_r + p_ext) : tmp_r;
    past     = stale ? (remain[31] ? 32'd0 : cur_r) : prev_r;
    cur_eff  = stale ? 32'd0 : cur_r;
    pend_eff = pend_r[31] ? 32'd0 : pend_r;
    flap     = pend_r[31] && (cur_eff == 32'd0) && (past <= 32'd1);
    elapsed  = now_r - start_r;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    period_nxt    = period_r;
    target_nxt    = target_r;
    start_nxt     = start_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    now_nxt       = now_r;
    inc_nxt       = inc_r;
    pend_nxt      = pend_r;
    tmp_nxt       = tmp_r;
    tot_a_nxt     = tot_a_r;
    res_upd_nxt   = res_upd_r;
    res_tot_nxt   = res_tot_r;
    res_ovs_nxt   = res_ovs_r;
    out_valid_nxt = out_valid_r;
    out_upd_nxt   = out_upd_r;
    out_tot_nxt   = out_tot_r;
    out_ovs_nxt   = out_ovs_r;
    mdu_cmd       = '0;

    // output beat leaves
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // configuration writes
    if (cfg_we) begin
      unique case (cfg_index)
        swrc_pkg::REG_PERIOD: period_nxt = cfg_wdata[30:0];
        swrc_pkg::REG_TARGET: target_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          now_nxt     = in_now_ms;
          inc_nxt     = in_increment;
          pend_nxt    = in_pending;
          res_upd_nxt = '0;
          res_tot_nxt = '0;
          res_ovs_nxt = '0;
          unique case (in_kind)
            swrc_pkg::KIND_UPDATE:    state_nxt = ST_UPD;
            swrc_pkg::KIND_TOTAL:     state_nxt = ST_TOT0;
            swrc_pkg::KIND_OVERSHOOT: state_nxt = ST_OVS0;
            default:                  state_nxt = ST_DONE;
          endcase
        end
      end

      // update inside the period, or step the start one period ahead
      ST_UPD: begin
        if (upd_dist < p_ext) begin
          cur_nxt     = cur_r + inc_r;
          res_upd_nxt = cur_r + inc_r;
          state_nxt   = ST_DONE;
        end else begin
          tmp_nxt   = start_r + p_ext;
          state_nxt = ST_ROT;
        end
      end

      // rotate buckets; restart at now (made even) when a full period or more went by past the next start
      ST_ROT: begin
        if (rot_dist >= p_ext) begin
          prev_nxt  = '0;
          start_nxt = {now_r[31:1], 1'b0};
        end else begin
          prev_nxt  = cur_r;
          start_nxt = {tmp_r[31:1], 1'b0};
        end
        cur_nxt     = inc_r;
        res_upd_nxt = inc_r;
        state_nxt   = ST_DONE;
      end

      // time left in the running period
      ST_TOT0: begin
        tmp_nxt   = start_r + p_ext - now_r;
        state_nxt = ST_TOT1;
      end

      // flapping shortcut, else past * remain
      ST_TOT1: begin
        if (flap) begin
          res_tot_nxt = past[0] ? {33'b0, period_r} : 64'd0;
          state_nxt   = ST_DONE;
        end else begin
          mdu_cmd.start = 1'b1;
          mdu_cmd.op    = swrc_pkg::MDU_MUL;
          mdu_cmd.a     = {1'b0, past};
          mdu_cmd.b     = remain;
          tot_a_nxt     = {1'b0, cur_eff} + {1'b0, pend_eff};
          state_nxt     = ST_TOT_P1;
        end
      end

      // add (cur + pending) * period
      ST_TOT_P1: begin
        if (mdu_rsp.done) begin
          mdu_cmd.start = 1'b1;
          mdu_cmd.op    = swrc_pkg::MDU_MAC;
          mdu_cmd.a     = tot_a_r;
          mdu_cmd.b     = p_ext;
          state_nxt     = ST_TOT_P2;
        end
      end

      ST_TOT_P2: begin
        if (mdu_rsp.done) begin
          res_tot_nxt = mdu_rsp.acc;
          state_nxt   = ST_DONE;
        end
      end

      // empty, future or stale window reads zero, a zero period reads cur, else start elapsed * target
      ST_OVS0: begin
        if (((cur_r == 32'd0) && (start_r == 32'd0)) || elapsed[31] || (elapsed > p_ext)) begin
          state_nxt = ST_DONE;
        end else if (period_r == 31'd0) begin
          res_ovs_nxt = cur_r;
          state_nxt   = ST_DONE;
        end else begin
          mdu_cmd.start = 1'b1;
          mdu_cmd.op    = swrc_pkg::MDU_MUL;
          mdu_cmd.a     = {1'b0, elapsed};
          mdu_cmd.b     = target_r;
          state_nxt     = ST_OVS_MUL;
        end
      end

      // elapsed * target / period
      ST_OVS_MUL: begin
        if (mdu_rsp.done) begin
          mdu_cmd.start = 1'b1;
          mdu_cmd.op    = swrc_pkg::MDU_DIV;
          mdu_cmd.b     = p_ext;
          state_nxt     = ST_OVS_DIV;
        end
      end

      ST_OVS_DIV: begin
        if (mdu_rsp.done) begin
          res_ovs_nxt = cur_r - mdu_rsp.acc[31:0];
          state_nxt   = ST_DONE;
        end
      end

      // hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_upd_nxt   = res_upd_r;
          out_tot_nxt   = res_tot_r;
          out_ovs_nxt   = res_ovs_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      period_r    <= 31'd1000;
      target_r    <= '0;
      start_r     <= '0;
      cur_r       <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      period_r    <= period_nxt;
      target_r    <= target_nxt;
      start_r     <= start_nxt;
      cur_r       <= cur_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
    now_r     <= now_nxt;
    inc_r     <= inc_nxt;
    pend_r    <= pend_nxt;
    tmp_r     <= tmp_nxt;
    tot_a_r   <= tot_a_nxt;
    res_upd_r <= res_upd_nxt;
    res_tot_r <= res_tot_nxt;
    res_ovs_r <= res_ovs_nxt;
    out_upd_r <= out_upd_nxt;
    out_tot_r <= out_tot_nxt;
    out_ovs_r <= out_ovs_nxt;
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_update_count = out_upd_r;
  assign out_total_events = out_tot_r;
  assign out_overshoot    = out_ovs_r;

  // stored period start is always even
  a_start_even: assert property (@(posedge clk) disable iff (!rst_n)
    start_r[0] == 1'b0)
    else $error("period start has bit 0 set");

  // the shared unit is never restarted while it runs
  a_mdu_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    mdu_cmd.start |-> !mdu_rsp.busy)
    else $error("shared unit started while busy");

  // a finishing pass is only seen in a state that waits for it
  a_mdu_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mdu_rsp.done |-> (state_r == ST_TOT_P1 || state_r == ST_TOT_P2 ||
                      state_r == ST_OVS_MUL || state_r == ST_OVS_DIV))
    else $error("shared unit finished with no one waiting");

  // a new output beat comes only from the result hand-off
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("output beat raised outside hand-off");

endmodule
